>>> sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;
  localparam int CAP_BITS    = 5;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle shift control broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/spq_req_if.sv
`default_nettype none

interface spq_req_if #(
  parameter int PRI_W = 16,
  parameter int PAY_W = 32
) ();
  logic              valid;
  logic              ready;
  spq_pkg::cmd_t     cmd;
  logic [PRI_W-1:0]  priority_in;
  logic [PAY_W-1:0]  payload_in;

  modport source (output valid, cmd, priority_in, payload_in, input ready);
  modport sink   (input valid, cmd, priority_in, payload_in, output ready);
endinterface

`default_nettype wire

>>> sv/spq_rsp_if.sv
`default_nettype none

interface spq_rsp_if #(
  parameter int PRI_W = 16,
  parameter int PAY_W = 32
) ();
  logic                                valid;
  logic                                ready;
  spq_pkg::status_t                    status;
  logic [PRI_W-1:0]                    priority_out;
  logic [PAY_W-1:0]                    payload_out;
  logic [spq_pkg::COUNT_BITS-1:0]      count_out;

  modport source (output valid, status, priority_out, payload_out, count_out, input ready);
  modport sink   (input valid, status, priority_out, payload_out, count_out, output ready);
endinterface

`default_nettype wire

>>> sv/spq_cell.sv
`default_nettype none

module spq_cell #(
  parameter int PRI_W = 16,
  parameter int PAY_W = 32
) (
  input  wire                     clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire                     occupied,
  input  wire                     left_keep,
  input  wire  [PRI_W-1:0]        left_pri,
  input  wire  [PAY_W-1:0]        left_pay,
  input  wire  [PRI_W-1:0]        right_pri,
  input  wire  [PAY_W-1:0]        right_pay,
  input  wire  [PRI_W-1:0]        new_pri,
  input  wire  [PAY_W-1:0]        new_pay,
  output logic                    keep,
  output logic [PRI_W-1:0]        pri,
  output logic [PAY_W-1:0]        pay
);
  import spq_pkg::*;

  // stays put on insert when it holds an entry of equal or higher priority
  assign keep = occupied && (pri >= new_pri);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (!keep) begin
        if (left_keep) begin
          pri <= new_pri;
          pay <= new_pay;
        end else begin
          pri <= left_pri;
          pay <= left_pay;
        end
      end
    end else if (ctl.deq) begin
      pri <= right_pri;
      pay <= right_pay;
    end
  end

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Sorted priority queue built from a chain of cells, highest priority in cell 0.
// req channel: valid/ready with cmd (enqueue, dequeue, peek, clear), priority_in
//   and payload_in. rsp channel: valid/ready with status, priority_out,
//   payload_out and count_out, exactly one response per request transfer.
// Each cell compares its own entry against the incoming priority and either
//   holds, loads the new entry or takes its neighbor's, so an insert or removal
//   finishes in the cycle of the transfer regardless of queue fill.
// Latency: the response is valid the cycle after the request transfer.
// Throughput: one command per cycle, limited only by the response register.
// cfg_we/cfg_data write the capacity limit (saturated at DEPTH); write only
//   while no request is in flight.
// Reset: queue empty, capacity 16, no response pending. Cell contents are not
//   cleared; only cells below the entry count are ever read.
// Stall: while rsp is held (valid and not ready) the response stays stable and
//   req.ready is low, so no new request is taken.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  spq_req_if.sink                       req,
  spq_rsp_if.source                     rsp,
  input  wire                           cfg_we,
  input  wire  [spq_pkg::CAP_BITS-1:0]  cfg_data
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  logic [CAP_BITS-1:0]      capacity;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     xfer;
  logic                     full;
  logic                     empty;
  cell_ctl_t                ctl;

  logic [DEPTH-1:0]         keep;
  logic [PRIORITY_BITS-1:0] cell_pri [DEPTH];
  logic [PAYLOAD_BITS-1:0]  cell_pay [DEPTH];

  status_t                  status_next;
  logic [PRIORITY_BITS-1:0] pri_next;
  logic [PAYLOAD_BITS-1:0]  pay_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign xfer      = req.valid && req.ready;

  assign full  = (count >= CNT_W'(DEPTH)) || (CMP_W'(count) >= CMP_W'(capacity));
  assign empty = (count == '0);

  assign ctl.enq = xfer && (req.cmd == CMD_ENQ) && !full;
  assign ctl.deq = xfer && (req.cmd == CMD_DEQ) && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                     occ;
      logic                     lk;
      logic [PRIORITY_BITS-1:0] lp;
      logic [PAYLOAD_BITS-1:0]  ld;
      logic [PRIORITY_BITS-1:0] rp;
      logic [PAYLOAD_BITS-1:0]  rd;

      assign occ = (CNT_W'(gi) < count);

      if (gi == 0) begin : g_head
        assign lk = 1'b1;
        assign lp = '0;
        assign ld = '0;
      end else begin : g_mid
        assign lk = keep[gi-1];
        assign lp = cell_pri[gi-1];
        assign ld = cell_pay[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign rp = '0;
        assign rd = '0;
      end else begin : g_body
        assign rp = cell_pri[gi+1];
        assign rd = cell_pay[gi+1];
      end

      spq_cell #(
        .PRI_W (PRIORITY_BITS),
        .PAY_W (PAYLOAD_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occupied  (occ),
        .left_keep (lk),
        .left_pri  (lp),
        .left_pay  (ld),
        .right_pri (rp),
        .right_pay (rd),
        .new_pri   (req.priority_in),
        .new_pay   (req.payload_in),
        .keep      (keep[gi]),
        .pri       (cell_pri[gi]),
        .pay       (cell_pay[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    pri_next    = '0;
    pay_next    = '0;
    unique case (req.cmd)
      CMD_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          pri_next = cell_pri[0];
          pay_next = cell_pay[0];
          if (req.cmd == CMD_DEQ) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (xfer) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      rsp.status       <= status_next;
      rsp.priority_out <= pri_next;
      rsp.payload_out  <= pay_next;
      rsp.count_out    <= COUNT_BITS'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (xfer && req.cmd == CMD_CLEAR) |=> (count == '0))
    else $error("clear did not empty the queue");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    xfer |=> rsp.valid)
    else $error("no response after request transfer");

  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_pri[0] >= cell_pri[1]))
    else $error("front cells out of order");
`endif

endmodule

`default_nettype wire

>>> bench/spq_result_check.sv
`timescale 1ns / 100ps

module spq_result_check #(
  parameter int DEPTH = 16,
  parameter int PRI_W = 16,
  parameter int PAY_W = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  spq_req_if                      req,
  spq_rsp_if                      rsp,
  input  logic                    cfg_we,
  input  logic [spq_pkg::CAP_BITS-1:0] cfg_data,
  output int                      fail_count,
  output int                      outstanding,
  output int                      checked,
  output int                      full_seen,
  output int                      empty_seen
);
  import spq_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [PRI_W-1:0]       pri;
    logic [PAY_W-1:0]       pay;
    logic [COUNT_BITS-1:0]  count;
  } queue_rsp_t;

  logic [PRI_W-1:0]    slot_pri [DEPTH];
  logic [PAY_W-1:0]    slot_pay [DEPTH];
  int                  held;
  logic [CAP_BITS-1:0] cap_limit;
  queue_rsp_t          awaited_rsp [$];

  function automatic queue_rsp_t apply_queue_cmd(cmd_t c, logic [PRI_W-1:0] p,
                                                 logic [PAY_W-1:0] d);
    queue_rsp_t r;
    int limit;
    int pos;
    r.status = ST_OK;
    r.pri = '0;
    r.pay = '0;
    limit = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
    case (c)
      CMD_ENQ: begin
        if (held >= limit) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held && slot_pri[pos] >= p) pos++;
          for (int i = held; i > pos; i--) begin
            slot_pri[i] = slot_pri[i-1];
            slot_pay[i] = slot_pay[i-1];
          end
          slot_pri[pos] = p;
          slot_pay[pos] = d;
          held++;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pri = slot_pri[0];
          r.pay = slot_pay[0];
          if (c == CMD_DEQ) begin
            for (int i = 1; i < held; i++) begin
              slot_pri[i-1] = slot_pri[i];
              slot_pay[i-1] = slot_pay[i];
            end
            held--;
          end
        end
      end
      default: begin
        held = 0;
      end
    endcase
    r.count = COUNT_BITS'(held);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    outstanding = 0;
    checked = 0;
    full_seen = 0;
    empty_seen = 0;
    held = 0;
    cap_limit = CAP_RESET;
  end

  always @(posedge clk) begin
    queue_rsp_t want;
    queue_rsp_t got;
    if (rst) begin
      held = 0;
      cap_limit = CAP_RESET;
      awaited_rsp.delete();
    end else begin
      if (cfg_we) begin
        cap_limit = cfg_data;
      end
      // response first: a request taken at this edge is queued only after this check
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.pri = rsp.priority_out;
        got.pay = rsp.payload_out;
        got.count = rsp.count_out;
        checked++;
        if (awaited_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: response with none pending: status %0d pri %h pay %h count %0d",
                     $time, got.status, got.pri, got.pay, got.count);
          end
        end else begin
          want = awaited_rsp.pop_front();
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_EMPTY) empty_seen++;
          if (got.status !== want.status || got.pri !== want.pri ||
              got.pay !== want.pay || got.count !== want.count) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: expected status %0d pri %h pay %h count %0d",
                       $time, want.status, want.pri, want.pay, want.count);
              $display("%0t:           got      status %0d pri %h pay %h count %0d",
                       $time, got.status, got.pri, got.pay, got.count);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_rsp.push_back(apply_queue_cmd(req.cmd, req.priority_in, req.payload_in));
      end
    end
    outstanding = awaited_rsp.size();
  end

endmodule

>>> bench/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH = 16;
  localparam int PRI_W = 16;
  localparam int PAY_W = 32;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int HOLD_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_data;
  logic                no_idle;
  int                  holds_wanted;
  int                  holds_done;
  int                  cycle_count;
  int                  fail_count;
  int                  outstanding;
  int                  checked;
  int                  full_seen;
  int                  empty_seen;

  spq_req_if #(.PRI_W(PRI_W), .PAY_W(PAY_W)) req_ch ();
  spq_rsp_if #(.PRI_W(PRI_W), .PAY_W(PAY_W)) rsp_ch ();

  sorted_priority_queue #(
    .DEPTH(DEPTH),
    .PAYLOAD_BITS(PAY_W),
    .PRIORITY_BITS(PRI_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  spq_result_check #(
    .DEPTH(DEPTH),
    .PRI_W(PRI_W),
    .PAY_W(PAY_W)
  ) u_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .checked(checked),
    .full_seen(full_seen),
    .empty_seen(empty_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue_tb: done, errors");
      $finish;
    end
  end

  task automatic send_cmd(cmd_t c, logic [PRI_W-1:0] p, logic [PAY_W-1:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.priority_in <= p;
    req_ch.payload_in <= d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // response side: random stall per transfer, long hold-off on request
  initial begin : response_sink
    int stall;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < holds_wanted) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stall = no_idle ? 0 : $urandom_range(4);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [CAP_BITS-1:0] cap_seq [N_PHASES];
    logic                filling;
    int                  seg_left;
    int                  r;
    cmd_t                c;
    logic [PRI_W-1:0]    pri;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    no_idle = 1'b0;
    holds_wanted = 0;
    holds_done = 0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ENQ;
    req_ch.priority_in = '0;
    req_ch.payload_in = '0;
    cap_seq = '{5'd31, 5'd16, 5'd5, 5'd10, 5'd3, 5'd1, 5'd0, 5'd16};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset capacity, empty reads, extremes, equal priorities keep arrival order
    send_cmd(CMD_DEQ, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_PEEK, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_CLEAR, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_ENQ, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_ENQ, 16'h8000, 32'h5555_AAAA);
    send_cmd(CMD_ENQ, 16'h8000, 32'hAAAA_5555);
    send_cmd(CMD_ENQ, 16'h0000, 32'h1234_5678);
    send_cmd(CMD_PEEK, 16'h0000, 32'h0000_0000);
    repeat (5) send_cmd(CMD_DEQ, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_DEQ, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_ENQ, 16'h1234, 32'hDEAD_BEEF);
    send_cmd(CMD_CLEAR, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_PEEK, 16'h0000, 32'h0000_0000);

    // capacity one, then capacity zero below the held count
    wait_idle();
    write_capacity(5'd1);
    send_cmd(CMD_ENQ, 16'h00FF, 32'h0F0F_0F0F);
    send_cmd(CMD_ENQ, 16'hFF00, 32'hF0F0_F0F0);
    wait_idle();
    write_capacity(5'd0);
    send_cmd(CMD_ENQ, 16'hFFFF, 32'h0000_0001);
    send_cmd(CMD_DEQ, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_ENQ, 16'h0001, 32'h8000_0000);
    send_cmd(CMD_PEEK, 16'h0000, 32'h0000_0000);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_capacity(cap_seq[ph]);
      filling = 1'b0;
      seg_left = 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (seg_left == 0) begin
          filling = !filling;
          seg_left = $urandom_range(40, 15);
          no_idle = ($urandom_range(3) == 0);
        end
        seg_left--;
        if ((ph == 0 || ph == 3) && k == 30) holds_wanted++;
        r = $urandom_range(99);
        if (filling) begin
          c = (r < 75) ? CMD_ENQ : (r < 88) ? CMD_DEQ : (r < 98) ? CMD_PEEK : CMD_CLEAR;
        end else begin
          c = (r < 25) ? CMD_ENQ : (r < 80) ? CMD_DEQ : (r < 97) ? CMD_PEEK : CMD_CLEAR;
        end
        case ($urandom_range(3))
          0: pri = PRI_W'($urandom_range(3));
          1: pri = 16'hFFFF - PRI_W'($urandom_range(2));
          default: pri = PRI_W'($urandom);
        endcase
        send_cmd(c, pri, PAY_W'($urandom));
      end
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (4) @(posedge clk);

    $display("%0d commands checked over %0d capacity settings (0 through 31), %0d refused, %0d empty",
             checked, N_PHASES + 3, full_seen, empty_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sorted_priority_queue_tb: done, clean");
    end else begin
      $display("sorted_priority_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/spq_pkg.sv
sv/spq_req_if.sv
sv/spq_rsp_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
bench/spq_result_check.sv
bench/sorted_priority_queue_tb.sv
